### rtl/coomv_pkg.sv
// ---------------------------------------------------------------------------
// coomv_pkg: shared types and constants
// Widths, codes and beat structs for the sparse COO matrix-vector block.
// ---------------------------------------------------------------------------
package coomv_pkg;

  localparam int unsigned VEC_DEPTH      = 1024;
  localparam int unsigned ADDR_W         = $clog2(VEC_DEPTH);
  localparam int unsigned IDX_W          = 10;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned FRAC_W         = 16;
  localparam int unsigned PROD_W         = 2 * DATA_W;
  localparam int unsigned SUM_W          = PROD_W - FRAC_W + 1;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned OUT_FIFO_DEPTH = 4;
  localparam int unsigned OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
  localparam int unsigned OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_WR_X    = 2'd0,
    ACT_WR_Y    = 2'd1,
    ACT_NONZERO = 2'd2,
    ACT_RD_Y    = 2'd3
  } action_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_MAC  = 2'd0,
    MODE_MSC  = 2'd1,
    MODE_TMAC = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [DATA_W-1:0] value;
    logic                    last_entry;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [IDX_W-1:0]         result_index;
    logic                     done_res;
  } out_t;

  typedef struct packed {
    logic       res_valid;
    logic [1:0] inflight;
  } dp_stat_t;

endpackage

### rtl/coomv_ram.sv
// ---------------------------------------------------------------------------
// coomv_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data; a read that
// meets a write to the same address returns the old contents.
// ---------------------------------------------------------------------------
module coomv_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/coomv_datapath.sv
// ---------------------------------------------------------------------------
// coomv_datapath: vector memories and read-modify-write pipeline
// Holds the source and accumulator vectors, multiplies in the first stage,
// adds with saturation and writes back in the second, with forwarding.
// ---------------------------------------------------------------------------
module coomv_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  coomv_pkg::in_t                item_i,
  input  logic [coomv_pkg::MODE_W-1:0]  mode_i,
  output coomv_pkg::dp_stat_t           stat_o,
  output coomv_pkg::out_t               res_o
);

  localparam int unsigned AW = coomv_pkg::ADDR_W;
  localparam int unsigned DW = coomv_pkg::DATA_W;
  localparam int unsigned SW = coomv_pkg::SUM_W;

  logic          trans;
  logic [AW-1:0] row_addr;
  logic [AW-1:0] col_addr;
  logic [AW-1:0] src_addr;
  logic [AW-1:0] dst_addr;
  logic          x_we;
  logic [DW-1:0] x_rdata;
  logic [DW-1:0] y_rdata;

  logic                 s1_v_q;
  logic [1:0]           s1_act_q;
  logic [AW-1:0]        s1_addr_q;
  logic signed [DW-1:0] s1_val_q;
  logic                 s1_last_q;
  logic                 s1_sub_q;

  logic                 s2_v_q;
  logic [1:0]           s2_act_q;
  logic [AW-1:0]        s2_addr_q;
  logic signed [DW-1:0] s2_val_q;
  logic                 s2_last_q;
  logic                 s2_sub_q;
  logic signed [DW-1:0] s2_y_q;
  logic signed [coomv_pkg::PROD_W-1:0] s2_prod_q;

  logic          wb_v_q;
  logic [AW-1:0] wb_addr_q;
  logic [DW-1:0] wb_data_q;

  logic signed [DW-1:0]                 y_fwd;
  logic signed [coomv_pkg::PROD_W-1:0] prod;
  logic signed [coomv_pkg::PROD_W-1:0] prod_shr;
  logic signed [SW-1:0]                 q_ext;
  logic signed [SW-1:0]                 y_ext;
  logic signed [SW-1:0]                 sum;
  logic                                 ovf_pos;
  logic                                 ovf_neg;
  logic signed [DW-1:0]                 sat;
  logic                                 y_we;
  logic [DW-1:0]                        y_wdata;

  assign trans    = (mode_i == coomv_pkg::MODE_TMAC);
  assign row_addr = item_i.row_index[AW-1:0];
  assign col_addr = item_i.col_index[AW-1:0];
  assign src_addr = trans ? row_addr : col_addr;
  assign dst_addr = trans ? col_addr : row_addr;
  assign x_we     = fire_i && (item_i.action == coomv_pkg::ACT_WR_X);

  coomv_ram #(
    .DEPTH (coomv_pkg::VEC_DEPTH),
    .WIDTH (DW)
  ) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (row_addr),
    .wdata_i (item_i.value),
    .re_i    (fire_i),
    .raddr_i (src_addr),
    .rdata_o (x_rdata)
  );

  coomv_ram #(
    .DEPTH (coomv_pkg::VEC_DEPTH),
    .WIDTH (DW)
  ) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .waddr_i (s2_addr_q),
    .wdata_i (y_wdata),
    .re_i    (fire_i),
    .raddr_i ((item_i.action == coomv_pkg::ACT_NONZERO) ? dst_addr : row_addr),
    .rdata_o (y_rdata)
  );

  // Stage 1 payload.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      s1_act_q  <= item_i.action;
      s1_addr_q <= (item_i.action == coomv_pkg::ACT_NONZERO) ? dst_addr : row_addr;
      s1_val_q  <= item_i.value;
      s1_last_q <= item_i.last_entry;
      s1_sub_q  <= (mode_i == coomv_pkg::MODE_MSC);
    end
  end

  // The newest pending write to the same entry wins over older data.
  always_comb begin
    if (y_we && (s2_addr_q == s1_addr_q)) begin
      y_fwd = $signed(y_wdata);
    end else if (wb_v_q && (wb_addr_q == s1_addr_q)) begin
      y_fwd = $signed(wb_data_q);
    end else begin
      y_fwd = $signed(y_rdata);
    end
  end

  assign prod = coomv_pkg::PROD_W'(s1_val_q) * coomv_pkg::PROD_W'($signed(x_rdata));

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_act_q  <= s1_act_q;
      s2_addr_q <= s1_addr_q;
      s2_val_q  <= s1_val_q;
      s2_last_q <= s1_last_q;
      s2_sub_q  <= s1_sub_q;
      s2_y_q    <= y_fwd;
      s2_prod_q <= prod;
    end
  end

  // Stage 2: floor shift, add or subtract, saturate.
  assign prod_shr = s2_prod_q >>> coomv_pkg::FRAC_W;
  assign q_ext    = prod_shr[SW-1:0];
  assign y_ext    = SW'(s2_y_q);
  assign sum      = s2_sub_q ? (y_ext - q_ext) : (y_ext + q_ext);
  assign ovf_pos  = !sum[SW-1] && (|sum[SW-2:DW-1]);
  assign ovf_neg  = sum[SW-1] && !(&sum[SW-2:DW-1]);

  always_comb begin
    if (ovf_pos) begin
      sat = {1'b0, {(DW-1){1'b1}}};
    end else if (ovf_neg) begin
      sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat = sum[DW-1:0];
    end
  end

  assign y_we    = s2_v_q && ((s2_act_q == coomv_pkg::ACT_WR_Y) ||
                              (s2_act_q == coomv_pkg::ACT_NONZERO));
  assign y_wdata = (s2_act_q == coomv_pkg::ACT_WR_Y) ? s2_val_q : sat;

  always_ff @(posedge clk_i) begin
    wb_addr_q <= s2_addr_q;
    wb_data_q <= y_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      wb_v_q <= 1'b0;
    end else begin
      s1_v_q <= fire_i;
      s2_v_q <= s1_v_q;
      wb_v_q <= y_we;
    end
  end

  always_comb begin
    res_o = '0;
    stat_o.res_valid = 1'b0;
    stat_o.inflight  = {1'b0, s1_v_q} + {1'b0, s2_v_q};
    if (s2_v_q && (s2_act_q == coomv_pkg::ACT_RD_Y)) begin
      stat_o.res_valid   = 1'b1;
      res_o.result_value = s2_y_q;
      res_o.result_index = coomv_pkg::IDX_W'(s2_addr_q);
    end else if (s2_v_q && (s2_act_q == coomv_pkg::ACT_NONZERO) && s2_last_q) begin
      stat_o.res_valid = 1'b1;
      res_o.done_res   = 1'b1;
    end
  end

  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |=> s2_v_q)
    else $error("stage 1 beat did not advance to stage 2");

  a_wb_tracks_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    y_we |=> (wb_v_q && (wb_addr_q == $past(s2_addr_q))))
    else $error("write-back register lost the last accumulator write");

  a_res_not_write_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.res_valid |-> !(y_we && (s2_act_q == coomv_pkg::ACT_WR_Y)))
    else $error("result produced by an accumulator write beat");

endmodule

### rtl/coomv_out_fifo.sv
// ---------------------------------------------------------------------------
// coomv_out_fifo: result buffer
// Small register FIFO that decouples the non-stalling pipeline from the
// output handshake.
// ---------------------------------------------------------------------------
module coomv_out_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  coomv_pkg::out_t                  data_i,
  input  logic                             pop_i,
  output logic                             valid_o,
  output coomv_pkg::out_t                  data_o,
  output logic [coomv_pkg::OUT_CNT_W-1:0]  count_o
);

  localparam int unsigned PW = coomv_pkg::OUT_PTR_W;
  localparam int unsigned CW = coomv_pkg::OUT_CNT_W;

  coomv_pkg::out_t mem_q [coomv_pkg::OUT_FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_q;
  logic [PW-1:0]   rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < CW'(coomv_pkg::OUT_FIFO_DEPTH)))
    else $error("result buffer overflow");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("result buffer count did not follow a push");

endmodule

### rtl/sparse_coo_matvec_accumulate.sv
// A read beat passes through stage 1, stage 2 and the result buffer on its way out.
// Throughput: one beat per cycle while input ready is high; the accumulator
// read-modify-write forwards from the two write stages, so its memory port sets
// the pace. Input ready drops only when the four-entry result buffer could fill.
// Reset clears the pipeline, the result buffer and op_mode to multiply-add;
// vector memories are not cleared and are undefined until written.
// ---------------------------------------------------------------------------
// sparse_coo_matvec_accumulate: COO sparse matrix-vector accumulate
// Q16.16 source and accumulator vectors in RAM, updated by streamed nonzeros.
// ---------------------------------------------------------------------------
module sparse_coo_matvec_accumulate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  coomv_pkg::in_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output coomv_pkg::out_t               out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [coomv_pkg::MODE_W-1:0]  cfg_data_i
);

  localparam int unsigned CW = coomv_pkg::OUT_CNT_W;

  logic [coomv_pkg::MODE_W-1:0] op_mode_q;
  logic [coomv_pkg::MODE_W-1:0] op_mode_d;
  logic                         in_fire;
  coomv_pkg::dp_stat_t          dp_stat;
  coomv_pkg::out_t              dp_res;
  logic [CW-1:0]                fifo_cnt;
  logic [CW:0]                  occupancy;

  assign cfg_ready_o = 1'b1;
  assign op_mode_d   = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : op_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= coomv_pkg::MODE_MAC;
    end else begin
      op_mode_q <= op_mode_d;
    end
  end

  assign occupancy  = (CW+1)'(fifo_cnt) + (CW+1)'(dp_stat.inflight);
  assign in_ready_o = (occupancy < (CW+1)'(coomv_pkg::OUT_FIFO_DEPTH));
  assign in_fire    = in_valid_i && in_ready_o;

  coomv_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .item_i (in_data_i),
    .mode_i (op_mode_q),
    .stat_o (dp_stat),
    .res_o  (dp_res)
  );

  coomv_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (dp_stat.res_valid),
    .data_i  (dp_res),
    .pop_i   (out_ready_i),
    .valid_o (out_valid_o),
    .data_o  (out_data_o),
    .count_o (fifo_cnt)
  );

endmodule

### test/coomv_tracker_pkg.sv
// ---------------------------------------------------------------------------
// coomv_tracker_pkg: expected-result tracking for the COO matvec block
// Mirrors the source and accumulator vectors and the mode register, works out
// the result of every accepted input beat and compares output beats with it.
// ---------------------------------------------------------------------------
package coomv_tracker_pkg;

  import coomv_pkg::*;

  class coo_accum_tracker;

    localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

    logic signed [DATA_W-1:0] x_mem [VEC_DEPTH];
    logic signed [DATA_W-1:0] y_mem [VEC_DEPTH];
    logic [MODE_W-1:0]        op_mode = MODE_MAC;
    out_t                     owed_results[$];
    int                       mismatch_count = 0;

    function void apply_beat(in_t b);
      logic [IDX_W-1:0] dst;
      logic [IDX_W-1:0] src;
      longint           prod;
      longint           acc;
      out_t             r;
      r = '0;
      case (b.action)
        ACT_WR_X: x_mem[b.row_index] = b.value;
        ACT_WR_Y: y_mem[b.row_index] = b.value;
        ACT_NONZERO: begin
          if (op_mode == MODE_TMAC) begin
            dst = b.col_index;
            src = b.row_index;
          end else begin
            dst = b.row_index;
            src = b.col_index;
          end
          // The arithmetic shift drops the low product bits, rounding toward minus infinity.
          prod = (longint'($signed(b.value)) * longint'(x_mem[src])) >>> FRAC_W;
          if (op_mode == MODE_MSC) begin
            acc = longint'(y_mem[dst]) - prod;
          end else begin
            acc = longint'(y_mem[dst]) + prod;
          end
          if (acc > SAT_HI) begin
            acc = SAT_HI;
          end else if (acc < SAT_LO) begin
            acc = SAT_LO;
          end
          y_mem[dst] = acc[DATA_W-1:0];
          if (b.last_entry) begin
            r.done_res = 1'b1;
            owed_results.push_back(r);
          end
        end
        default: begin
          r.result_value = y_mem[b.row_index];
          r.result_index = b.row_index;
          owed_results.push_back(r);
        end
      endcase
    endfunction

    task report(string msg);
      $display("result mismatch: %s", msg);
      mismatch_count++;
    endtask

    task compare_result(out_t got);
      out_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected beat value %h index %0d done %b",
                         got.result_value, got.result_index, got.done_res));
        return;
      end
      want = owed_results.pop_front();
      if (got.result_value !== want.result_value) begin
        report($sformatf("result_value got %h want %h", got.result_value, want.result_value));
      end
      if (got.result_index !== want.result_index) begin
        report($sformatf("result_index got %0d want %0d", got.result_index, want.result_index));
      end
      if (got.done_res !== want.done_res) begin
        report($sformatf("done_res got %b want %b", got.done_res, want.done_res));
      end
    endtask

  endclass

endpackage

### test/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for sparse_coo_matvec_accumulate
// Loads vectors, streams nonzeros under every mode setting and reads the
// accumulator back, with random gaps on both sides and one long output stall.
// ---------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import coomv_pkg::*;
  import coomv_tracker_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNDEF    = 2'd3;
  localparam int                PHASES        = 6;
  localparam int                PHASE_BEATS   = 320;
  localparam int                HOLD_CYCLES   = 300;
  localparam int                SETTLE_CYCLES = 8;
  localparam int                TAIL_CYCLES   = 20;
  localparam int                LIMIT_CYCLES  = 400000;
  localparam logic [MODE_W-1:0] PHASE_MODE [PHASES] =
    '{MODE_MSC, MODE_TMAC, MODE_UNDEF, MODE_MAC, MODE_TMAC, MODE_MSC};

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_t               in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_t              out_data_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [MODE_W-1:0] cfg_data_i  = '0;

  bit               idle_on     = 1'b1;
  bit               hold_req    = 1'b0;
  int               cycle_count = 0;
  int               x_rows[$];
  int               y_rows[$];
  bit               x_written [VEC_DEPTH];
  bit               y_written [VEC_DEPTH];
  coo_accum_tracker tracker = new;

  sparse_coo_matvec_accumulate DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end else begin
      if (in_valid_i && in_ready_o) begin
        tracker.apply_beat(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        tracker.compare_result(out_data_o);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        tracker.op_mode = cfg_data_i;
      end
    end
  end

  function automatic in_t make_beat(action_e act, int row, int col, logic [DATA_W-1:0] val,
                                    bit last);
    in_t b;
    b.action     = act;
    b.row_index  = IDX_W'(row);
    b.col_index  = IDX_W'(col);
    b.value      = val;
    b.last_entry = last;
    return b;
  endfunction

  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      2: case ($urandom_range(0, 5))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'h0000_0001;
        4: return 32'hFFFF_FFFF;
        default: return 32'h0001_0000;
      endcase
      default: return $urandom_range(0, 32'h0001_FFFF);
    endcase
  endfunction

  // Half the picks come from the first few written entries so that updates
  // to the same accumulator entry often follow each other closely.
  function automatic int pick_row(int rows[$]);
    int hot;
    hot = (rows.size() < 8) ? rows.size() : 8;
    if ($urandom_range(0, 1) == 0) begin
      return rows[$urandom_range(0, hot - 1)];
    end
    return rows[$urandom_range(0, rows.size() - 1)];
  endfunction

  function automatic in_t next_random_beat();
    int roll;
    int row;
    int dst;
    int src;
    roll = $urandom_range(0, 99);
    row  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, VEC_DEPTH - 1);
    if (roll < 10 || x_rows.size() == 0) begin
      return make_beat(ACT_WR_X, row, $urandom_range(0, VEC_DEPTH - 1), random_value(),
                       1'($urandom_range(0, 1)));
    end
    if (roll < 20 || y_rows.size() == 0) begin
      return make_beat(ACT_WR_Y, row, $urandom_range(0, VEC_DEPTH - 1), random_value(),
                       1'($urandom_range(0, 1)));
    end
    if (roll < 82) begin
      dst = pick_row(y_rows);
      src = pick_row(x_rows);
      if (tracker.op_mode == MODE_TMAC) begin
        return make_beat(ACT_NONZERO, src, dst, random_value(), $urandom_range(0, 19) == 0);
      end
      return make_beat(ACT_NONZERO, dst, src, random_value(), $urandom_range(0, 19) == 0);
    end
    return make_beat(ACT_RD_Y, pick_row(y_rows), $urandom_range(0, VEC_DEPTH - 1), $urandom,
                     1'($urandom_range(0, 1)));
  endfunction

  task automatic send_beat(in_t b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    if (b.action == ACT_WR_X && !x_written[b.row_index]) begin
      x_written[b.row_index] = 1'b1;
      x_rows.push_back(int'(b.row_index));
    end
    if (b.action == ACT_WR_Y && !y_written[b.row_index]) begin
      y_written[b.row_index] = 1'b1;
      y_rows.push_back(int'(b.row_index));
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_mode(logic [MODE_W-1:0] mode_val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain(int settle);
    in_valid_i <= 1'b0;
    while (tracker.owed_results.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  initial begin
    in_t directed[$];
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_mode(MODE_MAC);

    directed.push_back(make_beat(ACT_WR_X, 0, 0, 32'h0001_0000, 1'b0));
    directed.push_back(make_beat(ACT_WR_X, 1023, 1023, 32'h7FFF_FFFF, 1'b0));
    directed.push_back(make_beat(ACT_WR_X, 5, 0, 32'h8000_0000, 1'b1));
    directed.push_back(make_beat(ACT_WR_X, 1, 0, 32'h0000_0001, 1'b0));
    directed.push_back(make_beat(ACT_WR_Y, 0, 1023, 32'h0000_0000, 1'b0));
    directed.push_back(make_beat(ACT_WR_Y, 1023, 0, 32'h7FFF_FFFF, 1'b0));
    directed.push_back(make_beat(ACT_WR_Y, 5, 0, 32'h8000_0000, 1'b1));
    directed.push_back(make_beat(ACT_NONZERO, 0, 0, 32'h0002_0000, 1'b0));
    directed.push_back(make_beat(ACT_NONZERO, 1023, 1023, 32'h7FFF_FFFF, 1'b0));
    directed.push_back(make_beat(ACT_NONZERO, 5, 5, 32'h7FFF_FFFF, 1'b0));
    directed.push_back(make_beat(ACT_NONZERO, 0, 5, 32'hFFFF_FFFF, 1'b0));
    directed.push_back(make_beat(ACT_NONZERO, 0, 1023, 32'h8000_0000, 1'b0));
    directed.push_back(make_beat(ACT_NONZERO, 0, 1, 32'hFFFF_FFFF, 1'b0));
    directed.push_back(make_beat(ACT_RD_Y, 0, 1023, 32'hFFFF_FFFF, 1'b1));
    directed.push_back(make_beat(ACT_RD_Y, 1023, 0, 32'h0000_0000, 1'b0));
    directed.push_back(make_beat(ACT_RD_Y, 5, 0, 32'h0000_0000, 1'b0));
    directed.push_back(make_beat(ACT_NONZERO, 0, 0, 32'h0000_0000, 1'b1));
    directed.push_back(make_beat(ACT_NONZERO, 5, 0, 32'h0000_8000, 1'b1));
    directed.push_back(make_beat(ACT_RD_Y, 5, 0, 32'h0000_0000, 1'b0));
    directed.push_back(make_beat(ACT_RD_Y, 0, 0, 32'h0000_0000, 1'b0));
    foreach (directed[i]) begin
      send_beat(directed[i]);
    end
    drain(SETTLE_CYCLES);

    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p != PHASES - 1);
      write_mode(PHASE_MODE[p]);
      if (p == 1) begin
        hold_req = 1'b1;
      end
      repeat (PHASE_BEATS) send_beat(next_random_beat());
      drain((p == PHASES - 1) ? TAIL_CYCLES : SETTLE_CYCLES);
    end

    if (tracker.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

endmodule
